FILE: src/sisr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sisr_pkg
// shared types and constants of the scaled integer square root block
// ----------------------------------------------------------------------------
package sisr_pkg;

    localparam int WORD_W     = 32;
    localparam int EXP_W      = 6;
    localparam int ROOT_W     = 31;
    localparam int DIGIT_W    = 16;
    localparam int NORM_STEPS = 5;
    localparam int NSTEP_W    = 3;

    localparam logic signed [EXP_W-1:0] EXP_LOW    = -6'sd31;
    localparam logic signed [EXP_W-1:0] EXP_RAWMIN = -6'sd32;
    localparam logic [ROOT_W-1:0]       ROOT_MAX   = {ROOT_W{1'b1}};

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_NORM = 5'b00010,
        S_ODD  = 5'b00100,
        S_ROOT = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    typedef struct packed {
        logic               load;
        logic               norm;
        logic               odd;
        logic               root;
        logic               fin;
        logic [NSTEP_W-1:0] nstep;
    } t_ctrl;

endpackage

FILE: src/sisr_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sisr_seq
// sequencer: normalisation steps, odd fix, digit trials and final shift
// ----------------------------------------------------------------------------
module sisr_seq
    import sisr_pkg::*;
#(
    parameter int ROOT_BITS = 16,
    parameter int CW        = $clog2(ROOT_BITS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_out_free,
    output logic          o_busy,
    output t_ctrl         o_ctrl,
    output logic [CW-1:0] o_bit
);

    t_state             r_state, n_state;
    logic [NSTEP_W-1:0] r_nstep, n_nstep;
    logic [CW-1:0]      r_bit, n_bit;

    always_comb begin
        n_state = r_state;
        n_nstep = r_nstep;
        n_bit   = r_bit;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_NORM;
                    n_nstep = '0;
                end
            end
            S_NORM: begin
                if (r_nstep == NSTEP_W'(NORM_STEPS - 1)) begin
                    n_state = S_ODD;
                end else begin
                    n_nstep = r_nstep + 1'b1;
                end
            end
            S_ODD: begin
                n_state = S_ROOT;
                n_bit   = CW'(ROOT_BITS - 1);
            end
            S_ROOT: begin
                if (r_bit == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_bit = r_bit - 1'b1;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_nstep <= '0;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_nstep <= n_nstep;
            r_bit   <= n_bit;
        end
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_ctrl.load  = (r_state == S_IDLE) && i_start;
    assign o_ctrl.norm  = (r_state == S_NORM);
    assign o_ctrl.odd   = (r_state == S_ODD);
    assign o_ctrl.root  = (r_state == S_ROOT);
    assign o_ctrl.fin   = (r_state == S_DONE) && i_out_free;
    assign o_ctrl.nstep = r_nstep;
    assign o_bit        = r_bit;

endmodule

FILE: src/sisr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sisr_dp
// shared datapath: normalising shift, digit trial subtract and final shift
// ----------------------------------------------------------------------------
module sisr_dp
    import sisr_pkg::*;
#(
    parameter int ROOT_BITS = 16,
    parameter int CW        = $clog2(ROOT_BITS)
) (
    input  logic                    i_clk,
    input  t_ctrl                   i_ctrl,
    input  logic [CW-1:0]           i_bit,
    input  logic [WORD_W-1:0]       i_mantissa,
    input  logic signed [EXP_W-1:0] i_exponent,
    output logic [ROOT_W-1:0]       o_root
);

    logic [WORD_W-1:0]       r_m, n_m;
    logic signed [EXP_W-1:0] r_e, n_e;
    logic [4:0]              r_p, n_p;
    logic signed [6:0]       r_d, n_d;
    logic [WORD_W-1:0]       r_rem, n_rem;
    logic [DIGIT_W-1:0]      r_acc, n_acc;

    logic [4:0]              k;
    logic [WORD_W-1:0]       hi_mask;
    logic signed [7:0]       e_ext;
    logic signed [7:0]       p_next;
    logic signed [7:0]       d_raw;
    logic                    d_odd;
    logic [WORD_W-1:0]       m_fix;
    logic [5:0]              b_ext;
    logic [3:0]              b4;
    logic [WORD_W-1:0]       trial;
    logic signed [6:0]       sh;
    logic signed [6:0]       sh_neg;
    logic [WORD_W-1:0]       up;
    logic [DIGIT_W-1:0]      down;

    // normalising step of 16, 8, 4, 2 or 1 positions
    assign k       = 5'(5'd16 >> i_ctrl.nstep);
    assign hi_mask = ~(32'hFFFF_FFFF >> k);
    assign e_ext   = 8'(r_e);
    assign p_next  = $signed({3'b000, r_p}) + $signed({3'b000, k});

    // odd exponent fix
    assign d_raw = e_ext - $signed({3'b000, r_p});
    assign d_odd = d_raw[0];
    assign m_fix = d_odd ? (r_m >> 1) : r_m;

    // digit trial: (acc + 2^b)^2 - acc^2 = acc * 2^(b+1) + 2^(2b)
    assign b_ext = 6'(i_bit);
    assign b4    = b_ext[3:0];
    assign trial = ({16'b0, r_acc} << (5'(b4) + 5'd1)) | (32'd1 << {b4, 1'b0});

    // final scaling by half the remaining exponent
    assign sh     = r_d >>> 1;
    assign sh_neg = -sh;
    assign up     = {16'b0, r_acc} << sh[4:0];
    assign down   = r_acc >> sh_neg[3:0];

    always_comb begin
        n_m   = r_m;
        n_e   = r_e;
        n_p   = r_p;
        n_d   = r_d;
        n_rem = r_rem;
        n_acc = r_acc;
        if (i_ctrl.load) begin
            n_m = i_mantissa;
            n_e = (i_exponent == EXP_RAWMIN) ? EXP_LOW : i_exponent;
            n_p = '0;
        end else if (i_ctrl.norm) begin
            if (((r_m & hi_mask) == '0) && (p_next <= e_ext)) begin
                n_m = r_m << k;
                n_p = p_next[4:0];
            end
        end else if (i_ctrl.odd) begin
            n_m   = m_fix;
            n_d   = 7'(d_raw + 8'(d_odd));
            n_rem = m_fix;
            n_acc = '0;
        end else if (i_ctrl.root) begin
            if ((b_ext[5:4] == 2'b00) && (trial <= r_rem)) begin
                n_rem = r_rem - trial;
                n_acc = r_acc | (DIGIT_W'(1) << b4);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_m   <= n_m;
        r_e   <= n_e;
        r_p   <= n_p;
        r_d   <= n_d;
        r_rem <= n_rem;
        r_acc <= n_acc;
    end

    always_comb begin
        if (!r_d[6]) begin
            o_root = up[31] ? ROOT_MAX : up[ROOT_W-1:0];
        end else begin
            o_root = ROOT_W'(down);
        end
    end

endmodule

FILE: src/scaled_integer_square_root.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_integer_square_root
// approximate floor square root of mantissa times two to the exponent
// ----------------------------------------------------------------------------
// input channel: i_valid, o_stall, i_mantissa, i_exponent; a transfer takes
// place when i_valid is high and o_stall low. output channel: o_valid,
// i_stall, o_root; a transfer takes place when o_valid is high and i_stall
// low. the exponent pattern -32 is treated as -31.
// one item goes through five normalising shift steps, one odd-exponent fix,
// ROOT_BITS digit trials on a shared subtract-compare unit and one final
// shift into the output register. the block takes one item at a time and
// takes a new input only once the sequencer is back in idle.
// o_stall is high while an item is being worked on.
// a held result does not stop a new input transfer; the finished root waits
// in the last step until the output register is free.
// reset (synchronous, active low) returns the sequencer to idle and drops
// o_valid.
// ----------------------------------------------------------------------------
module scaled_integer_square_root
    import sisr_pkg::*;
#(
    parameter int ROOT_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [WORD_W-1:0]       i_mantissa,
    input  logic signed [EXP_W-1:0] i_exponent,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [ROOT_W-1:0]       o_root
);

    localparam int CW = $clog2(ROOT_BITS);

    t_ctrl              ctrl;
    logic [CW-1:0]      bit_idx;
    logic               busy;
    logic               start;
    logic               out_free;
    logic [ROOT_W-1:0]  root_val;
    logic               r_out_valid, n_out_valid;
    logic [ROOT_W-1:0]  r_root, n_root;

    assign start    = i_valid && !busy;
    assign out_free = !r_out_valid || !i_stall;

    sisr_seq #(
        .ROOT_BITS (ROOT_BITS),
        .CW        (CW)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_out_free (out_free),
        .o_busy     (busy),
        .o_ctrl     (ctrl),
        .o_bit      (bit_idx)
    );

    sisr_dp #(
        .ROOT_BITS (ROOT_BITS),
        .CW        (CW)
    ) u_dp (
        .i_clk      (i_clk),
        .i_ctrl     (ctrl),
        .i_bit      (bit_idx),
        .i_mantissa (i_mantissa),
        .i_exponent (i_exponent),
        .o_root     (root_val)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        n_root      = r_root;
        if (ctrl.fin) begin
            n_out_valid = 1'b1;
            n_root      = root_val;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_root <= n_root;
    end

    assign o_stall = busy;
    assign o_valid = r_out_valid;
    assign o_root  = r_root;

`ifndef SYNTHESIS
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> o_stall)
        else $error("sequencer not busy after input transfer");

    a_fin_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.fin |-> (!r_out_valid || !i_stall))
        else $error("result overwrites a held output");

    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({ctrl.load, ctrl.norm, ctrl.odd, ctrl.root, ctrl.fin}))
        else $error("more than one datapath step at once");

    a_valid_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(ctrl.fin))
        else $error("output valid without a finished item");
`endif

endmodule

FILE: tb/scaled_root_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_root_checker
// watches both channels of the scaled integer square root block, works out
// the root of every input transfer and compares each output transfer with
// the oldest root still due
// ----------------------------------------------------------------------------
module scaled_root_checker
    import sisr_pkg::*;
#(
    parameter int ROOT_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_stall,
    input  logic [WORD_W-1:0]       i_mantissa,
    input  logic signed [EXP_W-1:0] i_exponent,
    input  logic                    i_out_valid,
    input  logic                    i_out_stall,
    input  logic [ROOT_W-1:0]       i_root,
    output int                      o_errors,
    output int                      o_pending,
    output int                      o_accepted,
    output int                      o_checked
);

    typedef struct {
        logic [WORD_W-1:0]       mantissa;
        logic signed [EXP_W-1:0] exponent;
        logic [ROOT_W-1:0]       root;
    } t_root_due;

    t_root_due roots_due[$];

    initial begin
        o_errors   = 0;
        o_pending  = 0;
        o_accepted = 0;
        o_checked  = 0;
    end

    function automatic logic [ROOT_W-1:0] scaled_root(input logic [WORD_W-1:0] mant,
                                                      input logic signed [EXP_W-1:0] expo);
        int                e;
        int                p;
        int                d;
        int                b;
        logic [WORD_W-1:0] m;
        logic [63:0]       acc;
        logic [63:0]       trial;
        e = expo;
        if (e < EXP_LOW) begin
            e = EXP_LOW;
        end
        p = 0;
        m = mant;
        // normalise while room is left in the exponent
        while (!m[WORD_W-1] && p < e) begin
            p++;
            m = m << 1;
        end
        d = e - p;
        if (d % 2 != 0) begin
            p--;
            m = m >> 1;
            d = e - p;
        end
        acc = 64'd0;
        for (b = ROOT_BITS - 1; b >= 0; b--) begin
            trial = acc + (64'd1 << b);
            if (trial * trial <= {32'd0, m}) begin
                acc = trial;
            end
        end
        if (d >= 0) begin
            acc = acc << (d / 2);
        end else begin
            acc = acc >> ((-d) / 2);
        end
        return (acc > 64'(ROOT_MAX)) ? ROOT_MAX : acc[ROOT_W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_root_due due;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (roots_due.size() == 0) begin
                    report_mismatch($sformatf("root %0d with no transfer waiting", i_root));
                end else begin
                    due = roots_due.pop_front();
                    if (i_root !== due.root) begin
                        report_mismatch($sformatf("mantissa 0x%08h exponent %0d: root %0d, want %0d",
                                                  due.mantissa, due.exponent, i_root, due.root));
                    end
                    o_checked++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                due.mantissa = i_mantissa;
                due.exponent = i_exponent;
                due.root     = scaled_root(i_mantissa, i_exponent);
                roots_due.push_back(due);
                o_accepted++;
            end
            o_pending = roots_due.size();
        end
    end

endmodule

FILE: tb/scaled_integer_square_root_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_integer_square_root_tb
// drives mantissa and exponent transfers into the block under several idle
// and stall patterns, a long output hold-off and drain pauses; a checker
// beside the block predicts and compares every root
// ----------------------------------------------------------------------------
module scaled_integer_square_root_tb;
    import sisr_pkg::*;

    localparam int ROOT_BITS   = 16;
    localparam int LATENCY     = ROOT_BITS + 8;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 400;
    localparam int HOLD_ITEMS  = 150;
    localparam int CYCLE_LIMIT = 500000;

    logic                    i_clk      = 1'b0;
    logic                    i_rst_n    = 1'b0;
    logic                    i_valid    = 1'b0;
    logic                    o_stall;
    logic [WORD_W-1:0]       i_mantissa = '0;
    logic signed [EXP_W-1:0] i_exponent = '0;
    logic                    o_valid;
    logic                    i_stall    = 1'b0;
    logic [ROOT_W-1:0]       o_root;

    int gap_pct   = 0;
    int stall_pct = 0;
    bit hold_req  = 1'b0;
    int cycles    = 0;
    int errors;
    int pending;
    int accepted;
    int checked;

    int gap_by_phase[4]   = '{0, 72, 0, 20};
    int stall_by_phase[4] = '{0, 0, 72, 20};

    always #5 i_clk = ~i_clk;

    scaled_integer_square_root #(
        .ROOT_BITS(ROOT_BITS)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_mantissa(i_mantissa),
        .i_exponent(i_exponent),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_root(o_root)
    );

    scaled_root_checker #(
        .ROOT_BITS(ROOT_BITS)
    ) u_check (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_valid),
        .i_in_stall(o_stall),
        .i_mantissa(i_mantissa),
        .i_exponent(i_exponent),
        .i_out_valid(o_valid),
        .i_out_stall(i_stall),
        .i_root(o_root),
        .o_errors(errors),
        .o_pending(pending),
        .o_accepted(accepted),
        .o_checked(checked)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d roots still due", cycles, pending);
            $display("FAIL");
            $finish;
        end
    end

    // receiver: random stall, or a long hold-off when asked
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // entered and left at a falling edge
    task automatic push_item(input logic [WORD_W-1:0] m, input logic signed [EXP_W-1:0] x);
        while ($urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_mantissa <= m;
        i_exponent <= x;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic push_random();
        logic [WORD_W-1:0] m;
        logic [WORD_W-1:0] s;
        s = $urandom_range(0, 65535);
        case ($urandom_range(0, 3))
            0: m = $urandom;
            1: m = $urandom >> $urandom_range(0, 31);
            2: m = $urandom_range(0, 255);
            default: m = s * s - $urandom_range(0, 1);
        endcase
        push_item(m, EXP_W'($urandom_range(0, 63)));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // zero mantissa, saturation, range edges, odd and even exponents
        push_item(32'h0000_0000, 6'sd0);
        push_item(32'h0000_0000, 6'sd31);
        push_item(32'h0000_0000, EXP_RAWMIN);
        push_item(32'hFFFF_FFFF, 6'sd31);
        push_item(32'hFFFF_FFFF, 6'sd30);
        push_item(32'hFFFF_FFFF, 6'sd0);
        push_item(32'hFFFF_FFFF, EXP_LOW);
        push_item(32'hFFFF_FFFF, EXP_RAWMIN);
        push_item(32'h0000_0001, 6'sd0);
        push_item(32'h0000_0001, 6'sd31);
        push_item(32'h0000_0001, -6'sd1);
        push_item(32'h0000_0001, 6'sd1);
        push_item(32'h8000_0000, 6'sd0);
        push_item(32'h8000_0000, 6'sd1);
        push_item(32'h8000_0000, -6'sd1);
        push_item(32'h0000_0002, -6'sd2);
        push_item(32'h7FFF_FFFF, 6'sd5);
        push_item(32'h0000_0003, -6'sd3);
        push_item(32'hFFFE_0001, 6'sd0);
        push_item(32'h0001_0000, EXP_RAWMIN);
        push_item(32'h4000_0000, -6'sd30);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            gap_pct   = gap_by_phase[ph];
            stall_pct = stall_by_phase[ph];
            repeat (PHASE_ITEMS) push_random();
            wait_drained();
        end

        // output held off while input keeps offering
        gap_pct   = 0;
        stall_pct = 0;
        hold_req  = 1'b1;
        repeat (HOLD_ITEMS) push_random();
        wait_drained();
        repeat (LATENCY) @(negedge i_clk);

        $display("%0d transfers in, %0d roots checked, %0d mismatches", accepted, checked, errors);
        $display("covered edge values, idle and stall mixes, a long output hold-off and drains");
        if (errors == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
